[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");

// Check a consequence in the same cycle as its trigger
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Check a consequence in the cycle after its trigger
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[hdl/tlfs_pkg.sv]
// ----------------------------------------------------------------------------
// tlfs_pkg
// Types and codes shared by the three-level feedback scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package tlfs_pkg;

	// Request function codes
	localparam logic [1:0] FUNC_INSERT  = 2'd0;
	localparam logic [1:0] FUNC_EXECUTE = 2'd1;
	localparam logic [1:0] FUNC_STATUS  = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_LEVEL = 2'd1;
	localparam logic [1:0] ST_POOL_FULL = 2'd2;
	localparam logic [1:0] ST_EMPTY     = 2'd3;

	// Served task outcome codes
	localparam logic [1:0] OUT_NONE     = 2'd0;
	localparam logic [1:0] OUT_FINISHED = 2'd1;
	localparam logic [1:0] OUT_REQUEUED = 2'd2;
	localparam logic [1:0] OUT_DEMOTED  = 2'd3;

	// Level code that names no level
	localparam logic [1:0] LVL_NONE = 2'd0;

	// Pass count limits
	localparam logic [1:0] PASS_MAX    = 2'd3;
	localparam logic [1:0] PASS_DEMOTE = 2'd2;

	// Number of levels, index of the lowest one
	localparam int         NUM_LVL = 3;
	localparam logic [1:0] IDX_LOW = 2'd2;

	typedef struct packed {
		logic [1:0]  func;
		logic [16:0] task_id;
		logic [1:0]  level;
		logic [15:0] burst_time;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [1:0]  served_level;
		logic [1:0]  outcome;
		logic [16:0] served_id;
		logic [15:0] time_left;
		logic [4:0]  count_high;
		logic [4:0]  count_mid;
		logic [4:0]  count_low;
		logic [19:0] work_high;
		logic [19:0] work_mid;
		logic [19:0] work_low;
		logic [16:0] next_id;
	} rsp_t;

	// One queued task
	typedef struct packed {
		logic [1:0]  pass;
		logic [15:0] remain;
		logic [16:0] id;
	} entry_t;

	// Queue operation for one level
	typedef struct packed {
		logic   push;
		logic   pop;
		entry_t entry;
	} lvl_ctl_t;

	// Head state of one level, now and after the current operation
	typedef struct packed {
		logic   nonempty;
		entry_t head;
		logic   nonempty_nx;
		entry_t head_nx;
	} lvl_stat_t;

endpackage

`default_nettype wire

[hdl/tlfs_level.sv]
// ----------------------------------------------------------------------------
// tlfs_level
// One FIFO level: entry memory with registered read, head entry and the
// entry behind it kept in registers so a pop and a push fit in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tlfs_level #(
	parameter int DEPTH = 16,
	localparam int PW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tlfs_pkg::lvl_ctl_t  ctl,
	output logic [CW-1:0]       count,
	output logic [CW-1:0]       count_nx,
	output tlfs_pkg::lvl_stat_t stat
);

	tlfs_pkg::entry_t store_q [DEPTH];
	tlfs_pkg::entry_t head_ent_q;
	tlfs_pkg::entry_t head_ent_d;
	tlfs_pkg::entry_t next_ent_q;
	logic [PW-1:0]    head_q;
	logic [PW-1:0]    head_d;
	logic [PW-1:0]    tail_q;
	logic [PW-1:0]    tail_d;
	logic [PW-1:0]    rd_addr;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    count_d;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	// Advance pointers and count
	always_comb begin
		head_d = ctl.pop ? ptr_inc(head_q) : head_q;
		tail_d = ctl.push ? ptr_inc(tail_q) : tail_q;
		case ({ctl.push, ctl.pop})
			2'b10:   count_d = count_q + CW'(1);
			2'b01:   count_d = count_q - CW'(1);
			default: count_d = count_q;
		endcase
		rd_addr = ptr_inc(head_d);
	end

	// Pick the new head entry: the one behind it, or a push into an empty level
	always_comb begin
		if (ctl.pop) begin
			head_ent_d = (count_q == CW'(1)) ? ctl.entry : next_ent_q;
		end else if (ctl.push && count_q == '0) begin
			head_ent_d = ctl.entry;
		end else begin
			head_ent_d = head_ent_q;
		end
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		head_ent_q <= head_ent_d;
	end

	// Write at the tail; read the entry behind the new head, forwarding this write
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			store_q[tail_q] <= ctl.entry;
		end
		if (ctl.push && tail_q == rd_addr) begin
			next_ent_q <= ctl.entry;
		end else begin
			next_ent_q <= store_q[rd_addr];
		end
	end

	assign count            = count_q;
	assign count_nx         = count_d;
	assign stat.nonempty    = (count_q != '0);
	assign stat.head        = head_ent_q;
	assign stat.nonempty_nx = (count_d != '0);
	assign stat.head_nx     = head_ent_d;

	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CW'(DEPTH))
	`ASSERT_IMP(a_no_pop_empty, clk, arst_n, ctl.pop, count_q != '0)
	`ASSERT_IMP(a_no_push_full, clk, arst_n, ctl.push && !ctl.pop, count_q != CW'(DEPTH))
	`ASSERT_IMP(a_empty_ptrs, clk, arst_n, count_q == '0, head_q == tail_q)

endmodule

`default_nettype wire

[hdl/three_level_feedback_scheduler.sv]
// ----------------------------------------------------------------------------
// three_level_feedback_scheduler
// Multilevel feedback queue scheduler with high, middle and low levels.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid, req_stall, req): insert a task at a level,
//   execute one time unit on the head of the highest non-empty level, or
//   ask for status only. Response channel (rsp_valid, rsp_stall, rsp): one
//   result per request with the outcome, per-level counts and work, and
//   the id that the next execute would serve.
//   The result is registered and appears in the cycle after its request is taken.
//   Throughput: one request per cycle while the receiver does not stall. Each
//   level keeps its head entry and the entry behind it in registers, refilled
//   from the level memory's registered read port, so a pop and a push complete in the same cycle.
//   When the receiver stalls, the result register holds and req_stall rises
//   until the result is taken; a result taken in a cycle frees room for a
//   new request in that same cycle.
//   Reset empties all levels and clears the work sums; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module three_level_feedback_scheduler #(
	parameter int DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  tlfs_pkg::req_t   req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output tlfs_pkg::rsp_t   rsp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int TW = CW + 2;

	tlfs_pkg::lvl_ctl_t  ctl      [tlfs_pkg::NUM_LVL];
	tlfs_pkg::lvl_stat_t stat     [tlfs_pkg::NUM_LVL];
	logic [CW-1:0]       cnt      [tlfs_pkg::NUM_LVL];
	logic [CW-1:0]       cnt_nx   [tlfs_pkg::NUM_LVL];
	logic [19:0]         work_q   [tlfs_pkg::NUM_LVL];
	logic [19:0]         work_d   [tlfs_pkg::NUM_LVL];
	logic [19:0]         work_add [tlfs_pkg::NUM_LVL];
	logic [19:0]         work_sub [tlfs_pkg::NUM_LVL];

	tlfs_pkg::rsp_t      rsp_d;
	tlfs_pkg::rsp_t      rsp_q;
	logic                rsp_valid_q;
	logic                fire;
	logic [TW-1:0]       total;
	logic [1:0]          ins_idx;
	logic [1:0]          sel;
	logic                any_ne;
	tlfs_pkg::entry_t    srv;
	logic [15:0]         t_dec;
	logic [1:0]          pass_nx;
	logic                finished;
	logic                demote;

	// One queue per level
	for (genvar g = 0; g < tlfs_pkg::NUM_LVL; g++) begin : g_lvl
		tlfs_level #(
			.DEPTH(DEPTH)
		) u_level (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl[g]),
			.count    (cnt[g]),
			.count_nx (cnt_nx[g]),
			.stat     (stat[g])
		);
	end

	assign fire      = req_valid && !req_stall;
	assign req_stall = rsp_valid_q && rsp_stall;
	assign total     = TW'(cnt[0]) + TW'(cnt[1]) + TW'(cnt[2]);
	assign ins_idx   = req.level - 2'd1;

	// Find the highest non-empty level and its head
	always_comb begin
		any_ne = 1'b1;
		if (stat[0].nonempty) begin
			sel = 2'd0;
			srv = stat[0].head;
		end else if (stat[1].nonempty) begin
			sel = 2'd1;
			srv = stat[1].head;
		end else begin
			sel    = tlfs_pkg::IDX_LOW;
			srv    = stat[2].head;
			any_ne = stat[2].nonempty;
		end
	end

	// Serve one time unit and classify the outcome
	always_comb begin
		if (srv.remain != '0) begin
			t_dec   = srv.remain - 16'd1;
			pass_nx = (srv.pass == tlfs_pkg::PASS_MAX) ? srv.pass : srv.pass + 2'd1;
		end else begin
			t_dec   = srv.remain;
			pass_nx = srv.pass;
		end
		finished = (t_dec == '0);
		demote   = !finished && sel != tlfs_pkg::IDX_LOW && pass_nx == tlfs_pkg::PASS_DEMOTE;
	end

	// Decode the request into queue operations and work changes
	always_comb begin
		for (int i = 0; i < tlfs_pkg::NUM_LVL; i++) begin
			ctl[i]      = '0;
			work_add[i] = '0;
			work_sub[i] = '0;
		end
		rsp_d = '0;
		unique case (req.func)
			tlfs_pkg::FUNC_INSERT: begin
				if (req.level == tlfs_pkg::LVL_NONE) begin
					rsp_d.status = tlfs_pkg::ST_BAD_LEVEL;
				end else if (total >= TW'(DEPTH)) begin
					rsp_d.status = tlfs_pkg::ST_POOL_FULL;
				end else begin
					for (int i = 0; i < tlfs_pkg::NUM_LVL; i++) begin
						if (ins_idx == 2'(i)) begin
							ctl[i].push  = fire;
							ctl[i].entry = tlfs_pkg::entry_t'{pass: 2'd0,
								remain: req.burst_time, id: req.task_id};
							work_add[i]  = 20'(req.burst_time);
						end
					end
				end
			end
			tlfs_pkg::FUNC_EXECUTE: begin
				if (!any_ne) begin
					rsp_d.status = tlfs_pkg::ST_EMPTY;
				end else begin
					rsp_d.served_level = sel + 2'd1;
					rsp_d.served_id    = srv.id;
					rsp_d.time_left    = t_dec;
					if (finished) begin
						rsp_d.outcome = tlfs_pkg::OUT_FINISHED;
					end else if (demote) begin
						rsp_d.outcome = tlfs_pkg::OUT_DEMOTED;
					end else begin
						rsp_d.outcome = tlfs_pkg::OUT_REQUEUED;
					end
					for (int i = 0; i < tlfs_pkg::NUM_LVL; i++) begin
						if (sel == 2'(i)) begin
							ctl[i].pop  = fire;
							work_sub[i] = (finished || demote) ? 20'(srv.remain) : 20'd1;
							if (!finished && !demote) begin
								ctl[i].push  = fire;
								ctl[i].entry = tlfs_pkg::entry_t'{pass: pass_nx,
									remain: t_dec, id: srv.id};
							end
						end
						if (demote && sel + 2'd1 == 2'(i)) begin
							ctl[i].push  = fire;
							ctl[i].entry = tlfs_pkg::entry_t'{pass: 2'd0,
								remain: t_dec, id: srv.id};
							work_add[i]  = 20'(t_dec);
						end
					end
				end
			end
			default: begin
				rsp_d.status = tlfs_pkg::ST_OK;
			end
		endcase

		// Report the state after this request
		for (int i = 0; i < tlfs_pkg::NUM_LVL; i++) begin
			work_d[i] = work_q[i] + work_add[i] - work_sub[i];
		end
		rsp_d.count_high = 5'(cnt_nx[0]);
		rsp_d.count_mid  = 5'(cnt_nx[1]);
		rsp_d.count_low  = 5'(cnt_nx[2]);
		rsp_d.work_high  = work_d[0];
		rsp_d.work_mid   = work_d[1];
		rsp_d.work_low   = work_d[2];
		if (stat[0].nonempty_nx) begin
			rsp_d.next_id = stat[0].head_nx.id;
		end else if (stat[1].nonempty_nx) begin
			rsp_d.next_id = stat[1].head_nx.id;
		end else if (stat[2].nonempty_nx) begin
			rsp_d.next_id = stat[2].head_nx.id;
		end else begin
			rsp_d.next_id = '0;
		end
	end

	// Hold work sums and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tlfs_pkg::NUM_LVL; i++) begin
				work_q[i] <= '0;
			end
			rsp_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				for (int i = 0; i < tlfs_pkg::NUM_LVL; i++) begin
					work_q[i] <= work_d[i];
				end
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`ASSERT_ALWAYS(a_pool_bound, clk, arst_n, total <= TW'(DEPTH))
	`ASSERT_IMP(a_empty_rsp, clk, arst_n, rsp_valid && rsp.status == tlfs_pkg::ST_EMPTY, rsp.served_level == tlfs_pkg::LVL_NONE && rsp.outcome == tlfs_pkg::OUT_NONE)
	`ASSERT_NEXT(a_insert_grows, clk, arst_n, fire && req.func == tlfs_pkg::FUNC_INSERT && rsp_d.status == tlfs_pkg::ST_OK, total == $past(total) + TW'(1))

endmodule

`default_nettype wire

[dv/three_level_feedback_scheduler_tb.sv]
// ----------------------------------------------------------------------------
// three_level_feedback_scheduler_tb
// Self-checking bench for the three-level feedback scheduler. A short
// directed table walks insert, execute and status requests through reset
// state, bad levels, zero bursts, requeue, demotion and low-level passes.
// Random fill, drain and mixed phases follow. Every response is compared
// field by field against an in-bench model or a pinned row's expected
// response, with random request gaps and random response-side stalls.
// ----------------------------------------------------------------------------
module three_level_feedback_scheduler_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         POOL_DEPTH  = 16;
	localparam int         CYCLE_LIMIT = 200000;
	localparam int         PHASES      = 13;
	localparam int         PHASE_LEN   = 50;
	localparam logic [1:0] FUNC_SPARE  = 2'd3;
	localparam logic [1:0] LVL_HIGH    = 2'd1;
	localparam logic [1:0] LVL_MID     = 2'd2;
	localparam logic [1:0] LVL_LOW     = 2'd3;
	localparam logic [16:0] ID_TOP     = 17'd99998;

	// Phase kinds of the random part
	localparam int PH_FILL  = 0;
	localparam int PH_DRAIN = 1;
	localparam int PH_MIX   = 2;

	localparam tlfs_pkg::rsp_t RSP_IDLE  = '0;
	localparam tlfs_pkg::rsp_t RSP_EMPTY = '{status: tlfs_pkg::ST_EMPTY, default: '0};
	localparam tlfs_pkg::rsp_t RSP_BAD   = '{status: tlfs_pkg::ST_BAD_LEVEL, default: '0};

	typedef struct {
		tlfs_pkg::req_t r;
		bit             pinned;
		tlfs_pkg::rsp_t want;
	} stim_row_t;

	localparam int NROW = 22;

	logic           clk;
	logic           arst_n;
	logic           req_valid;
	logic           req_stall;
	tlfs_pkg::req_t req;
	logic           rsp_valid;
	logic           rsp_stall;
	tlfs_pkg::rsp_t rsp;

	// Task queues of the model, high level first
	tlfs_pkg::entry_t lvl_q [3][$];
	tlfs_pkg::rsp_t   rsp_due [$];
	stim_row_t        pinned_q [$];
	bit               no_idle;
	int               mism;
	int               cycles;

	// Directed requests, from reset
	stim_row_t plan [NROW] = '{
		'{'{tlfs_pkg::FUNC_STATUS,  17'd0,  tlfs_pkg::LVL_NONE, 16'd0},    1'b1, RSP_IDLE},
		'{'{tlfs_pkg::FUNC_EXECUTE, 17'd0,  tlfs_pkg::LVL_NONE, 16'd0},    1'b1, RSP_EMPTY},
		'{'{tlfs_pkg::FUNC_INSERT,  ID_TOP, tlfs_pkg::LVL_NONE, 16'hFFFF}, 1'b1, RSP_BAD},
		'{'{FUNC_SPARE,             ID_TOP, LVL_LOW,            16'hFFFF}, 1'b1, RSP_IDLE},
		'{'{tlfs_pkg::FUNC_INSERT,  ID_TOP, LVL_HIGH, 16'd0},              1'b0, RSP_IDLE},
		'{'{tlfs_pkg::FUNC_INSERT,  17'd0,  LVL_HIGH, 16'hFFFF},           1'b0, RSP_IDLE},
		'{'{tlfs_pkg::FUNC_INSERT,  17'd12345, LVL_MID, 16'd2},            1'b0, RSP_IDLE},
		'{'{tlfs_pkg::FUNC_INSERT,  17'd777, LVL_LOW, 16'd1},              1'b0, RSP_IDLE},
		'{'{tlfs_pkg::FUNC_INSERT,  17'd5,  tlfs_pkg::LVL_NONE, 16'd3},    1'b0, RSP_IDLE},
		'{'{tlfs_pkg::FUNC_EXECUTE, 17'd0,  tlfs_pkg::LVL_NONE, 16'd0},    1'b0, RSP_IDLE},
		'{'{tlfs_pkg::FUNC_EXECUTE, 17'd0,  tlfs_pkg::LVL_NONE, 16'd0},    1'b0, RSP_IDLE},
		'{'{tlfs_pkg::FUNC_EXECUTE, ID_TOP, LVL_LOW,  16'hFFFF},           1'b0, RSP_IDLE},
		'{'{tlfs_pkg::FUNC_EXECUTE, 17'd0,  tlfs_pkg::LVL_NONE, 16'd0},    1'b0, RSP_IDLE},
		'{'{tlfs_pkg::FUNC_EXECUTE, 17'd0,  tlfs_pkg::LVL_NONE, 16'd0},    1'b0, RSP_IDLE},
		'{'{tlfs_pkg::FUNC_EXECUTE, 17'd0,  tlfs_pkg::LVL_NONE, 16'd0},    1'b0, RSP_IDLE},
		'{'{tlfs_pkg::FUNC_EXECUTE, 17'd0,  tlfs_pkg::LVL_NONE, 16'd0},    1'b0, RSP_IDLE},
		'{'{tlfs_pkg::FUNC_EXECUTE, 17'd0,  tlfs_pkg::LVL_NONE, 16'd0},    1'b0, RSP_IDLE},
		'{'{tlfs_pkg::FUNC_EXECUTE, 17'd0,  tlfs_pkg::LVL_NONE, 16'd0},    1'b0, RSP_IDLE},
		'{'{tlfs_pkg::FUNC_EXECUTE, 17'd0,  tlfs_pkg::LVL_NONE, 16'd0},    1'b0, RSP_IDLE},
		'{'{tlfs_pkg::FUNC_EXECUTE, 17'd0,  tlfs_pkg::LVL_NONE, 16'd0},    1'b0, RSP_IDLE},
		'{'{tlfs_pkg::FUNC_EXECUTE, 17'd0,  tlfs_pkg::LVL_NONE, 16'd0},    1'b0, RSP_IDLE},
		'{'{tlfs_pkg::FUNC_STATUS,  ID_TOP, LVL_MID,  16'hFFFF},           1'b0, RSP_IDLE}
	};

	three_level_feedback_scheduler #(
		.DEPTH(POOL_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Remaining work held at one level
	function automatic logic [19:0] level_work(int lv);
		logic [19:0] sum;
		sum = '0;
		for (int i = 0; i < lvl_q[lv].size(); i++) sum += 20'(lvl_q[lv][i].remain);
		return sum;
	endfunction

	// Apply one request to the scheduler state and return its response
	function automatic tlfs_pkg::rsp_t sched_response(tlfs_pkg::req_t r);
		tlfs_pkg::rsp_t   o;
		tlfs_pkg::entry_t e;
		int               lv;
		int               held;
		o = '0;
		lv = -1;
		held = lvl_q[0].size() + lvl_q[1].size() + lvl_q[2].size();
		case (r.func)
			tlfs_pkg::FUNC_INSERT: begin
				if (r.level == tlfs_pkg::LVL_NONE) begin
					o.status = tlfs_pkg::ST_BAD_LEVEL;
				end else if (held >= POOL_DEPTH) begin
					o.status = tlfs_pkg::ST_POOL_FULL;
				end else begin
					e.id = r.task_id;
					e.remain = r.burst_time;
					e.pass = '0;
					lvl_q[r.level - 1].push_back(e);
				end
			end
			tlfs_pkg::FUNC_EXECUTE: begin
				for (int i = 0; i < tlfs_pkg::NUM_LVL; i++)
					if (lv < 0 && lvl_q[i].size() != 0) lv = i;
				if (lv < 0) begin
					o.status = tlfs_pkg::ST_EMPTY;
				end else begin
					e = lvl_q[lv].pop_front();
					o.served_level = 2'(lv + 1);
					o.served_id = e.id;
					// a zero burst is neither decremented nor counted as a pass
					if (e.remain != 0) begin
						e.remain--;
						if (e.pass != tlfs_pkg::PASS_MAX) e.pass++;
					end
					o.time_left = e.remain;
					if (e.remain == 0) begin
						o.outcome = tlfs_pkg::OUT_FINISHED;
					end else if (lv == tlfs_pkg::IDX_LOW || e.pass != tlfs_pkg::PASS_DEMOTE) begin
						o.outcome = tlfs_pkg::OUT_REQUEUED;
						lvl_q[lv].push_back(e);
					end else begin
						o.outcome = tlfs_pkg::OUT_DEMOTED;
						e.pass = '0;
						lvl_q[lv + 1].push_back(e);
					end
				end
			end
			default: ;
		endcase
		o.count_high = 5'(lvl_q[0].size());
		o.count_mid  = 5'(lvl_q[1].size());
		o.count_low  = 5'(lvl_q[2].size());
		o.work_high  = level_work(0);
		o.work_mid   = level_work(1);
		o.work_low   = level_work(2);
		for (int i = tlfs_pkg::NUM_LVL - 1; i >= 0; i--)
			if (lvl_q[i].size() != 0) o.next_id = lvl_q[i][0].id;
		return o;
	endfunction

	// Compare one response field, report the first few misses
	function automatic void cmp_field(string nm, int unsigned want, int unsigned got);
		if (want != got) begin
			mism++;
			if (mism <= 10)
				$display("mismatch %s: expected %0d, got %0d at %0t", nm, want, got, $realtime);
		end
	endfunction

	// Random request whose mix depends on the phase kind
	function automatic tlfs_pkg::req_t rand_req(int kind);
		tlfs_pkg::req_t r;
		int             pick;
		int             ins_cut;
		int             sz;
		pick = $urandom_range(0, 99);
		ins_cut = (kind == PH_FILL) ? 65 : (kind == PH_DRAIN) ? 20 : 45;
		if (pick < ins_cut)
			r.func = tlfs_pkg::FUNC_INSERT;
		else if (pick < 91)
			r.func = tlfs_pkg::FUNC_EXECUTE;
		else if (pick < 96)
			r.func = tlfs_pkg::FUNC_STATUS;
		else
			r.func = FUNC_SPARE;
		r.task_id = 17'($urandom_range(0, 99998));
		r.level = ($urandom_range(0, 19) == 0) ? tlfs_pkg::LVL_NONE : 2'($urandom_range(1, 3));
		// mostly short bursts so tasks finish and move between levels
		sz = $urandom_range(0, 99);
		if (sz < 65)
			r.burst_time = 16'($urandom_range(0, 4));
		else if (sz < 97)
			r.burst_time = 16'($urandom_range(5, 40));
		else
			r.burst_time = 16'($urandom());
		return r;
	endfunction

	// Drive one request at the falling edge and hold it until taken
	task automatic send_req(tlfs_pkg::req_t r);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!(req_valid && !req_stall));
		@(negedge clk);
	endtask

	// Response side: random stall before each response
	initial begin
		int hold;
		rsp_stall = 1'b0;
		@(negedge clk);
		forever begin
			hold = no_idle ? 0 : $urandom_range(0, 8);
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid);
			@(negedge clk);
		end
	end

	// Predict on each taken request, check each taken response
	always @(posedge clk) begin
		tlfs_pkg::rsp_t want;
		tlfs_pkg::rsp_t got;
		stim_row_t      row;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				want = sched_response(req);
				if (pinned_q.size() != 0) begin
					row = pinned_q.pop_front();
					if (row.pinned) want = row.want;
				end
				rsp_due.push_back(want);
			end
			if (rsp_valid && !rsp_stall) begin
				got = rsp;
				if (rsp_due.size() == 0) begin
					mism++;
					if (mism <= 10)
						$display("unexpected response at %0t: %p", $realtime, got);
				end else begin
					want = rsp_due.pop_front();
					cmp_field("status", want.status, got.status);
					cmp_field("served_level", want.served_level, got.served_level);
					cmp_field("outcome", want.outcome, got.outcome);
					cmp_field("served_id", want.served_id, got.served_id);
					cmp_field("time_left", want.time_left, got.time_left);
					cmp_field("count_high", want.count_high, got.count_high);
					cmp_field("count_mid", want.count_mid, got.count_mid);
					cmp_field("count_low", want.count_low, got.count_low);
					cmp_field("work_high", want.work_high, got.work_high);
					cmp_field("work_mid", want.work_mid, got.work_mid);
					cmp_field("work_low", want.work_low, got.work_low);
					cmp_field("next_id", want.next_id, got.next_id);
				end
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Reset, directed table, random phases, drain
	initial begin
		stim_row_t      row;
		tlfs_pkg::req_t r;
		mism = 0;
		cycles = 0;
		no_idle = 1'b0;
		req_valid = 1'b0;
		req = '0;
		arst_n = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < NROW; i++) begin
			pinned_q.push_back(plan[i]);
			send_req(plan[i].r);
		end

		for (int p = 0; p < PHASES; p++) begin
			no_idle = (p % 4 == 3);
			for (int k = 0; k < PHASE_LEN; k++) begin
				r = rand_req(p % 3);
				row.r = r;
				row.pinned = 1'b0;
				row.want = '0;
				pinned_q.push_back(row);
				send_req(r);
			end
		end
		req_valid <= 1'b0;
		no_idle = 1'b0;

		// wait out the outstanding responses, then the pipeline
		while (rsp_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (mism == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[filelist.f]
+incdir+hdl
hdl/tlfs_pkg.sv
hdl/tlfs_level.sv
hdl/three_level_feedback_scheduler.sv
dv/three_level_feedback_scheduler_tb.sv
